FILE: sv/wms_pkg.sv
// Shared constants for the window maximum suppression block.
`default_nettype none

package wms_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_RADIUS  = 2;
	localparam int WIN_SIDE    = 2 * MAX_RADIUS + 1;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
	localparam int DIM_W  = 11;
	localparam int RAD_W  = 2;
	localparam int BANK_W = $clog2(WIN_SIDE);
	localparam int IDX_W  = $clog2(WIN_SIDE);
	localparam int POS_W  = 2 * DIM_W;
	localparam int LAG_W  = DIM_W + RAD_W + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = FPTR_W + 1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(512);
	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [7:0] MARK_EDGE = 8'd0;
	localparam logic [7:0] MARK_NONE = 8'd255;

endpackage

`default_nettype wire

FILE: sv/window_max_suppression.sv
// Square-window non-maximum suppression over a raster stream of edge pixels.
//
// Usage: raster pixels arrive on the s_axis channel with tuser low (a push);
// once the whole frame is in, requests with tuser high (drains) release the
// results still pending. Each result leaves on m_axis, tlast marking the last
// pixel of the frame. The result for pixel n appears with the push of pixel
// n + r*W + r, so the first r*W + r pushes give nothing and as many drains
// follow at the end of the frame.
// A result passes stage 1, stage 2 and the output queue before it is valid.
// Throughput: one request per cycle while s_axis_tready is high. Five row banks
// in one memory, read once per cycle at a single column, give the vertical
// maxima; a shift line of column maxima gives the window. For frames of no
// more than r rows, the block advances the window alone after the last push,
// with s_axis_tready low.
// Registers on the cfg channel: 0 width, 1 height, 2 radius. A write to one of
// them aborts the frame, and tready stays low for one cycle after it.
// Reset clears counters and valid flags and sets cfg_wait_q; row memory is not cleared.
// When the receiver stalls, results collect in a four-entry output queue and
// tready falls before it can overflow.
`default_nettype none

module window_max_suppression (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Request input: tdata = pixel_in[7:0]; tuser = operation
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [7:0]              s_axis_tdata,
	input  wire logic                    s_axis_tuser,
	// Result output: tdata = mark_out[7:0]; tlast = frame_last
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [7:0]                   m_axis_tdata,
	output logic                         m_axis_tlast,
	// Configuration writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [wms_pkg::DIM_W-1:0] cfg_data
);
	import wms_pkg::*;

	// Configuration registers and derived frame figures.
	logic [DIM_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;
	logic [DIM_W-1:0] eff_w, eff_h;
	logic [RAD_W-1:0] eff_r;
	logic [POS_W-1:0] wh_q;
	logic [LAG_W-1:0] lag_q;
	logic             cfg_wait_q;
	logic             cfg_fire;

	// Position counters of the advancing window front.
	logic [POS_W-1:0]  n_q;
	logic [COL_W-1:0]  xn_q;
	logic [ROW_W-1:0]  yn_q;
	logic [BANK_W-1:0] bank_q;
	logic [DIM_W-1:0]  ox_q;
	logic [DIM_W-1:0]  oy_q;
	logic              done_q;

	// Stage 1 and stage 2 pipeline registers.
	logic                v_s1, emit_s1, last_s1;
	logic [WIN_SIDE-1:0] rmask_s1, hmask_s1;
	logic [BANK_W-1:0]   bank_s1;
	logic [7:0]          fwd_s1;
	logic [RAD_W-1:0]    r_s1;
	logic [WIN_SIDE-1:0][7:0] rd_s1;

	logic                emit_s2, last_s2;
	logic [WIN_SIDE-1:0] hmask_s2;
	logic [RAD_W-1:0]    r_s2;

	logic [7:0] ent_max_q [WIN_SIDE];
	logic [7:0] ent_ctr_q [WIN_SIDE];

	// Row memory: one lane per row bank, addressed by column.
	logic [WIN_SIDE-1:0][7:0] row_mem [MAX_WIDTH];

	// Output queue.
	logic [8:0]        fifo_mem [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] fifo_cnt_q;

	logic s_fire, push_go, drain_go, catchup, adv, emit0, last0;
	logic [WIN_SIDE-1:0] rmask0, hmask0;
	logic [FCNT_W+1:0] occupancy;
	logic [7:0] cmax, centre1, hmax, centre2, mark2;
	logic fifo_push, fifo_pop;

	// Registers are used saturated to their legal range.
	always_comb begin
		eff_w = (width_q == '0) ? DIM_W'(1) :
			(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
		eff_h = (height_q == '0) ? DIM_W'(1) :
			(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
		eff_r = (radius_q == '0) ? RAD_W'(1) :
			(radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
	end

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// A frame shorter than the lag keeps the window front moving on its own.
	assign catchup   = done_q && (n_q < POS_W'(lag_q));
	assign occupancy = (FCNT_W+2)'(fifo_cnt_q) + (FCNT_W+2)'(emit_s1) +
		(FCNT_W+2)'(emit_s2);
	assign s_axis_tready = !cfg_wait_q && !catchup &&
		(occupancy < (FCNT_W+2)'(FIFO_DEPTH));
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign push_go  = s_fire && (s_axis_tuser == OP_PUSH) && !done_q;
	assign drain_go = s_fire && (s_axis_tuser == OP_DRAIN) && done_q;
	assign adv      = push_go || drain_go || catchup;
	assign emit0    = (push_go || drain_go) && (n_q >= POS_W'(lag_q));
	assign last0    = emit0 && (ox_q == eff_w - DIM_W'(1)) &&
		(oy_q == eff_h - DIM_W'(1));

	// Rows of the vertical span that lie inside the frame, and columns of
	// the horizontal span that lie inside the row.
	always_comb begin
		int k;
		int col;
		for (k = 0; k < WIN_SIDE; k++) begin
			rmask0[k] = (k <= 2 * int'(eff_r)) && (int'(yn_q) >= k) &&
				(int'(yn_q) - k < int'(eff_h));
			col = int'(ox_q) + int'(eff_r) - k;
			hmask0[k] = (k <= 2 * int'(eff_r)) && (col >= 0) && (col < int'(eff_w));
		end
	end

	// Configuration, frame figures and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			radius_q   <= RADIUS_RESET;
			wh_q       <= '0;
			lag_q      <= '0;
			cfg_wait_q <= 1'b1;
			n_q        <= '0;
			xn_q       <= '0;
			yn_q       <= '0;
			bank_q     <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			wh_q  <= POS_W'(eff_w) * POS_W'(eff_h);
			lag_q <= LAG_W'(eff_r) * LAG_W'(eff_w) + LAG_W'(eff_r);
			cfg_wait_q <= 1'b0;
			if (cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
					cfg_index == REG_RADIUS)) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default:    radius_q <= cfg_data[RAD_W-1:0];
				endcase
				cfg_wait_q <= 1'b1;
				n_q    <= '0;
				xn_q   <= '0;
				yn_q   <= '0;
				bank_q <= '0;
				ox_q   <= '0;
				oy_q   <= '0;
				done_q <= 1'b0;
			end else if (last0) begin
				n_q    <= '0;
				xn_q   <= '0;
				yn_q   <= '0;
				bank_q <= '0;
				ox_q   <= '0;
				oy_q   <= '0;
				done_q <= 1'b0;
			end else if (adv) begin
				n_q <= n_q + POS_W'(1);
				if (push_go && (n_q == wh_q - POS_W'(1))) begin
					done_q <= 1'b1;
				end
				if (DIM_W'(xn_q) + DIM_W'(1) == eff_w) begin
					xn_q   <= '0;
					yn_q   <= yn_q + ROW_W'(1);
					bank_q <= (bank_q == BANK_W'(WIN_SIDE - 1)) ? '0 : bank_q + BANK_W'(1);
				end else begin
					xn_q <= xn_q + COL_W'(1);
				end
				if (emit0) begin
					if (ox_q == eff_w - DIM_W'(1)) begin
						ox_q <= '0;
						oy_q <= oy_q + DIM_W'(1);
					end else begin
						ox_q <= ox_q + DIM_W'(1);
					end
				end
			end
		end
	end

	// Row memory: the pushed pixel goes inverted into its bank lane, while
	// all lanes are read at the same column. The new row comes by forwarding.
	always_ff @(posedge clk) begin
		rd_s1 <= row_mem[xn_q];
		if (push_go) begin
			row_mem[xn_q][bank_q] <= MARK_NONE - s_axis_tdata;
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= adv && !cfg_fire;
			emit_s1 <= emit0 && !cfg_fire;
			last_s1 <= last0;
		end
	end

	always_ff @(posedge clk) begin
		rmask_s1 <= rmask0;
		hmask_s1 <= hmask0;
		bank_s1  <= bank_q;
		fwd_s1   <= MARK_NONE - s_axis_tdata;
		r_s1     <= eff_r;
	end

	// Vertical maximum of one column and the centre row value.
	always_comb begin
		int k;
		int lane;
		logic [7:0] val;
		cmax    = '0;
		centre1 = '0;
		for (k = 0; k < WIN_SIDE; k++) begin
			lane = int'(bank_s1) + WIN_SIDE - k;
			if (lane >= WIN_SIDE) begin
				lane = lane - WIN_SIDE;
			end
			val = (k == 0) ? fwd_s1 : rd_s1[lane];
			if (rmask_s1[k] && (val > cmax)) begin
				cmax = val;
			end
			if (k == int'(r_s1)) begin
				centre1 = val;
			end
		end
	end

	// Shift line of column maxima and stage 2 control.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			ent_max_q[0] <= cmax;
			ent_ctr_q[0] <= centre1;
			for (int j = 1; j < WIN_SIDE; j++) begin
				ent_max_q[j] <= ent_max_q[j-1];
				ent_ctr_q[j] <= ent_ctr_q[j-1];
			end
		end
		hmask_s2 <= hmask_s1;
		r_s2     <= r_s1;
		last_s2  <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
		end
	end

	// Horizontal maximum over the columns inside the row.
	always_comb begin
		hmax = '0;
		for (int j = 0; j < WIN_SIDE; j++) begin
			if (hmask_s2[j] && (ent_max_q[j] > hmax)) begin
				hmax = ent_max_q[j];
			end
		end
		centre2 = ent_ctr_q[IDX_W'(r_s2)];
		mark2   = ((centre2 != '0) && (centre2 == hmax)) ? MARK_EDGE : MARK_NONE;
	end

	// Output queue.
	assign fifo_push     = emit_s2;
	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign fifo_pop      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = fifo_mem[rd_ptr_q][7:0];
	assign m_axis_tlast  = fifo_mem[rd_ptr_q][8];

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_mem[wr_ptr_q] <= {last_s2, mark2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (fifo_push) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (fifo_pop) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + FCNT_W'(fifo_push) - FCNT_W'(fifo_pop);
		end
	end

`ifndef SYNTHESIS
	// The credit check must keep the queue from ever taking a result it has
	// no room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> (fifo_cnt_q < FCNT_W'(FIFO_DEPTH)) || fifo_pop)
		else $error("output queue overflow");

	// While the window front runs on its own, no request may be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		catchup |-> !s_axis_tready)
		else $error("request taken during window catch-up");

	// An emitting request that no register write cancels always reaches stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit0 && !cfg_fire) |=> ##1 emit_s2)
		else $error("emitted result lost in pipeline");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/wms_checker.sv
// Checker for the window maximum suppression block: predicts and compares results.
`default_nettype none

module wms_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	input  wire logic                         s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,
	input  wire logic                         s_axis_tuser,
	input  wire logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [7:0]                   m_axis_tdata,
	input  wire logic                         m_axis_tlast,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [wms_pkg::DIM_W-1:0]    cfg_data,
	output int                                errors,
	output int                                marks_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import wms_pkg::*;

	localparam int STORE_DEPTH = WIN_SIDE * (MAX_WIDTH + 1);

	typedef struct packed {
		logic [7:0] mark;
		logic       last;
	} mark_t;

	mark_t       mark_q[$];
	logic [7:0]  inv_store[STORE_DEPTH];
	logic [10:0] width_reg, height_reg;
	logic [1:0]  radius_reg;
	int          in_col, in_row, out_col, out_row;
	bit          frame_in;

	assign marks_pending = mark_q.size();

	function automatic int cur_w();
		if (width_reg == 0) return 1;
		return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
	endfunction

	function automatic int cur_h();
		if (height_reg == 0) return 1;
		return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
	endfunction

	function automatic int cur_r();
		if (radius_reg == 0) return 1;
		return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
	endfunction

	// Symmetric reflection, then a clamp for windows wider than the image.
	function automatic int reflect(int i, int n);
		if (i < 0) i = -1 - i;
		if (i >= n) i = 2 * n - 1 - i;
		if (i < 0) i = 0;
		if (i >= n) i = n - 1;
		return i;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		frame_in = 0;
	endfunction

	function automatic void predict_mark();
		int w, h, r, y, x;
		logic [7:0] peak, centre, v;
		mark_t m;
		w = cur_w();
		h = cur_h();
		r = cur_r();
		peak = 0;
		for (int dy = -r; dy <= r; dy++) begin
			y = reflect(out_row + dy, h);
			for (int dx = -r; dx <= r; dx++) begin
				x = reflect(out_col + dx, w);
				v = inv_store[(y * w + x) % STORE_DEPTH];
				if (v > peak) peak = v;
			end
		end
		centre = inv_store[(out_row * w + out_col) % STORE_DEPTH];
		m.mark = (centre != 0 && centre == peak) ? MARK_EDGE : MARK_NONE;
		m.last = 0;
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) begin
				m.last = 1;
				restart_frame();
			end
		end
		mark_q.push_back(m);
	endfunction

	function automatic void take_request(logic op, logic [7:0] pix);
		int w, h, n;
		w = cur_w();
		h = cur_h();
		if (op == OP_DRAIN) begin
			if (frame_in) predict_mark();
			return;
		end
		if (frame_in) return;
		n = in_row * w + in_col;
		inv_store[n % STORE_DEPTH] = 8'd255 - pix;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (n + 1 >= w * h) begin
			frame_in = 1;
			in_col = 0;
			in_row = 0;
		end
		if (n >= cur_r() * w + cur_r()) predict_mark();
	endfunction

	task automatic report(string what, int got, int want);
		$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		radius_reg = RADIUS_RESET;
		restart_frame();
	end

	always @(posedge clk) begin
		mark_t want;
		if (arst_n) begin
			// Results are checked before the requests of the same edge are predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				if (mark_q.size() == 0) begin
					report("unexpected result, mark", m_axis_tdata, -1);
				end else begin
					want = mark_q.pop_front();
					if (m_axis_tdata !== want.mark) report("mark", m_axis_tdata, want.mark);
					if (m_axis_tlast !== want.last) report("frame last", m_axis_tlast, want.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH: begin
						width_reg = cfg_data;
						restart_frame();
					end
					REG_HEIGHT: begin
						height_reg = cfg_data;
						restart_frame();
					end
					REG_RADIUS: begin
						radius_reg = cfg_data[1:0];
						restart_frame();
					end
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) take_request(s_axis_tuser, s_axis_tdata);
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench top for the window maximum suppression block: stimulus and verdict.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wms_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [7:0]          m_axis_tdata;
	logic                m_axis_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [DIM_W-1:0]    cfg_data;
	int                  errors;
	int                  marks_pending;
	int                  quiet_cycles;
	bit                  sink_bursty;

	window_max_suppression u_dut (.*);

	wms_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Random gap length: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side stalls at random; some stretches accept every cycle.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) sink_bursty <= ~sink_bursty;
		if (sink_bursty) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 99) < 65);
	end

	// Watchdog: the run fails if nothing is accepted for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [7:0] pix, bit use_gaps);
		int gap;
		gap = use_gaps ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		while (marks_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(int w, int h, int r);
		go_idle();
		write_reg(REG_WIDTH, DIM_W'(w));
		write_reg(REG_HEIGHT, DIM_W'(h));
		write_reg(REG_RADIUS, RAD_W'(r));
	endtask

	// Edge-like pixel: many zeros and near-zero values so that marks occur.
	function automatic logic [7:0] edge_pixel();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3) return 8'd255;
		if (roll < 5) return 8'd0;
		if (roll < 8) return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	// One whole frame of pushes, an extra push, then enough drains to empty it, plus a spare.
	task automatic run_frame(int w, int h, int r, bit use_gaps);
		int wr, lag;
		wr = (w > MAX_WIDTH) ? MAX_WIDTH : ((w == 0) ? 1 : w);
		lag = r * wr + r;
		for (int i = 0; i < wr * h; i++) send_request(OP_PUSH, edge_pixel(), use_gaps);
		// A push after the frame is in must be ignored.
		send_request(OP_PUSH, 8'($urandom_range(0, 255)), use_gaps);
		for (int i = 0; i < lag && i < wr * h; i++)
			send_request(OP_DRAIN, 8'($urandom_range(0, 255)), use_gaps);
		// Drain with nothing pending.
		send_request(OP_DRAIN, 8'hA5, use_gaps);
	endtask

	initial begin
		int pushed, w, h, r;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_PUSH;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_WIDTH;
		cfg_data      = '0;
		sink_bursty   = 1'b0;
		quiet_cycles  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a drain before the frame ends, pixel extremes on a 3x3 image.
		set_shape(3, 3, 1);
		send_request(OP_DRAIN, 8'h00, 0);
		send_request(OP_PUSH, 8'd0, 0);
		send_request(OP_PUSH, 8'd255, 0);
		send_request(OP_PUSH, 8'h55, 0);
		send_request(OP_PUSH, 8'hAA, 0);
		send_request(OP_PUSH, 8'd0, 0);
		send_request(OP_PUSH, 8'd1, 0);
		send_request(OP_PUSH, 8'd254, 0);
		send_request(OP_PUSH, 8'd0, 0);
		send_request(OP_PUSH, 8'd255, 0);
		for (int i = 0; i < 5; i++) send_request(OP_DRAIN, 8'hFF, 0);

		// Window larger than the image: single pixel and one column, radius 2.
		set_shape(1, 1, 2);
		run_frame(1, 1, 2, 0);
		set_shape(1, 4, 2);
		run_frame(1, 4, 2, 0);

		// A write to the unused register 3 leaves a half-filled frame, which the next writes abort.
		set_shape(4, 4, 1);
		for (int i = 0; i < 7; i++) send_request(OP_PUSH, edge_pixel(), 0);
		go_idle();
		write_reg(2'd3, DIM_W'(7));

		// Saturation of the registers: zero sizes, oversized width, radius 0 and 3.
		set_shape(0, 0, 0);
		run_frame(0, 0, 1, 1);
		set_shape(5, 2, 3);
		run_frame(5, 2, 2, 1);
		// The oversized width takes part of a row, which the next write drops.
		set_shape(2047, 1, 2);
		for (int i = 0; i < 16; i++) send_request(OP_PUSH, edge_pixel(), 1);

		// Random frames, mostly small, with random gaps.
		pushed = 0;
		while (pushed < 220) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			r = $urandom_range(1, 2);
			set_shape(w, h, r);
			run_frame(w, h, r, 1);
			pushed += w * h;
		end
		// One tall frame, one pixel wide.
		set_shape(1, 40, 2);
		run_frame(1, 40, 2, 1);

		go_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && marks_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: window_max_suppression.f
sv/wms_pkg.sv
sv/window_max_suppression.sv
tb/sv/wms_checker.sv
tb/sv/tb.sv
